>>> hw/rtl/glut_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamma ramp generator package
// Shared widths, the log2 lookup table and the exp2 coefficient builder.
// All functions here are evaluated on constants during elaboration.
// ----------------------------------------------------------------------------
package glut_pkg;

    // Configuration register addresses (word index into the register map).
    typedef enum logic [1:0] {
        REG_GAMMA      = 2'd0,
        REG_CONTRAST   = 2'd1,
        REG_BRIGHTNESS = 2'd2
    } t_reg_idx;

    localparam int unsigned GAMMA_MIN = 41;
    localparam int unsigned MAX_LEVEL_Q8 = 65280;

    typedef logic [19:0] t_log_tab [256];

    // Integer square root of a 64-bit value.
    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > v) b = b >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Log2 of n (1..4096) in Q16, by repeated squaring of the mantissa.
    function automatic longint unsigned log2_q16(input longint unsigned n);
        longint unsigned top;
        longint unsigned m;
        longint unsigned frac;
        top = 0;
        frac = 0;
        for (int k = 0; k < 13; k++) begin
            if ((n >> (k + 1)) != 0) top = longint'(k + 1);
        end
        m = n << (30 - top);
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (top << 16) | frac;
    endfunction

    // Log2 table over all 8-bit indices; index zero is never used.
    function automatic t_log_tab log_table();
        t_log_tab t;
        t[0] = '0;
        for (int k = 1; k < 256; k++) begin
            t[k] = 20'(log2_q16(longint'(k)));
        end
        return t;
    endfunction

    // Weight of fraction bit j of the exponent: 2^-(2^-j) in Q30.
    function automatic logic [30:0] exp_coef(input int j);
        longint unsigned c;
        c = 64'd1 << 29;
        for (int k = 1; k <= 16; k++) begin
            if (k <= j) c = isqrt64(c << 30);
        end
        return 31'(c);
    endfunction

endpackage

>>> hw/rtl/glut_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division of a 32-bit dividend by a 15-bit divisor, four quotient
// bits per stage over eight stages. A one-bit tag travels with each request.
// ----------------------------------------------------------------------------
module glut_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic        i_tag,
    input  logic [31:0] i_num,
    input  logic [14:0] i_den,
    output logic        o_valid,
    output logic        o_tag,
    output logic [31:0] o_quo
);
    localparam int STAGES = 8;
    localparam int BITS = 4;

    logic        r_valid [STAGES];
    logic        r_tag   [STAGES];
    logic [14:0] r_rem   [STAGES];
    logic [31:0] r_num   [STAGES];
    logic [31:0] r_quo   [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic        in_valid;
        logic        in_tag;
        logic [14:0] in_rem;
        logic [31:0] in_num;
        logic [31:0] in_quo;
        logic [14:0] n_rem;
        logic [31:0] n_num;
        logic [31:0] n_quo;

        // Stage inputs come from the port or from the previous stage.
        if (s == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_tag   = i_tag;
            assign in_rem   = '0;
            assign in_num   = i_num;
            assign in_quo   = '0;
        end else begin : g_next
            assign in_valid = r_valid[s-1];
            assign in_tag   = r_tag[s-1];
            assign in_rem   = r_rem[s-1];
            assign in_num   = r_num[s-1];
            assign in_quo   = r_quo[s-1];
        end

        // Four shift-and-subtract steps.
        always_comb begin
            logic [15:0] rem;
            rem   = '0;
            n_rem = in_rem;
            n_num = in_num;
            n_quo = in_quo;
            for (int k = 0; k < BITS; k++) begin
                rem   = {n_rem, n_num[31]};
                n_num = {n_num[30:0], 1'b0};
                if (rem >= {1'b0, i_den}) begin
                    rem   = rem - {1'b0, i_den};
                    n_quo = {n_quo[30:0], 1'b1};
                end else begin
                    n_quo = {n_quo[30:0], 1'b0};
                end
                n_rem = rem[14:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= in_valid;
            end
            if (i_en) begin
                r_tag[s] <= in_tag;
                r_rem[s] <= n_rem;
                r_num[s] <= n_num;
                r_quo[s] <= n_quo;
            end
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_tag   = r_tag[STAGES-1];
    assign o_quo   = r_quo[STAGES-1];

endmodule

>>> hw/rtl/glut_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined exp2 unit
// Forms 2^-e in Q30 from e in Q16: one constant multiply per fraction bit,
// sixteen stages, then a final stage shifts by the integer part.
// ----------------------------------------------------------------------------
module glut_exp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic        i_zero,
    input  logic [31:0] i_e,
    output logic        o_valid,
    output logic [30:0] o_y
);
    import glut_pkg::*;

    localparam int MSTAGES = 16;
    localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

    logic        r_valid [MSTAGES];
    logic        r_zero  [MSTAGES];
    logic [31:0] r_e     [MSTAGES];
    logic [30:0] r_r     [MSTAGES];
    logic        r_out_valid;
    logic [30:0] r_y;

    for (genvar s = 0; s < MSTAGES; s++) begin : g_stage
        localparam logic [30:0] COEF = exp_coef(s + 1);
        logic        in_valid;
        logic        in_zero;
        logic [31:0] in_e;
        logic [30:0] in_r;
        logic [61:0] prod;
        logic [30:0] n_r;

        if (s == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_zero  = i_zero;
            assign in_e     = i_e;
            assign in_r     = ONE_Q30;
        end else begin : g_next
            assign in_valid = r_valid[s-1];
            assign in_zero  = r_zero[s-1];
            assign in_e     = r_e[s-1];
            assign in_r     = r_r[s-1];
        end

        // Multiply in this bit's weight when the exponent bit is set.
        assign prod = in_r * COEF;
        assign n_r  = in_e[15-s] ? prod[60:30] : in_r;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= in_valid;
            end
            if (i_en) begin
                r_zero[s] <= in_zero;
                r_e[s]    <= in_e;
                r_r[s]    <= n_r;
            end
        end
    end

    // Integer part shifts the result; 31 or more gives zero.
    logic [15:0] ip;
    logic [30:0] n_y;
    assign ip = r_e[MSTAGES-1][31:16];

    always_comb begin
        if (r_zero[MSTAGES-1] || ip >= 16'd31) begin
            n_y = '0;
        end else begin
            n_y = r_r[MSTAGES-1] >> ip[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid[MSTAGES-1];
        end
        if (i_en) begin
            r_y <= n_y;
        end
    end

    assign o_valid = r_out_valid;
    assign o_y     = r_y;

endmodule

>>> hw/rtl/gamma_ramp_entry_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamma ramp entry generator
// Turns a ramp index into one gamma-ramp word: 255*(i/N)^(1/gamma), scaled
// by contrast, offset by brightness, clamped to 0..255 and shifted left by 8.
// ----------------------------------------------------------------------------
// The block takes one request per clock while o_ready is high. Each passes
// the log2 lookup register, the divider stages that scale by 1/gamma, the
// exp2 multiply chain, the contrast and brightness registers and the output
// register. A two-entry output buffer keeps the input side moving while one
// finished result waits to be taken; o_ready drops once its skid entry fills.
// Configuration registers are read live by the divider, contrast and
// brightness stages, so write them only while no request is in flight.
module gamma_ramp_entry_generator_unit #(
    parameter int RAMP_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ramp_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_ramp_word,
    output logic        o_level_clamped
);
    import glut_pkg::*;

    localparam t_log_tab LOG_TAB = log_table();
    localparam logic [19:0] LOG_N = 20'(log2_q16(longint'(RAMP_ENTRIES)));
    localparam logic [12:0] ENTRIES_W = 13'(RAMP_ENTRIES);
    localparam logic [7:0] LAST_IDX = 8'(RAMP_ENTRIES - 1);

    // Configuration registers.
    logic [14:0] r_gamma;
    logic [14:0] r_contrast;
    logic [16:0] r_brightness;
    t_reg_idx    reg_idx;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma      <= 15'd4096;
            r_contrast   <= 15'd4096;
            r_brightness <= 17'd256;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_GAMMA:      r_gamma      <= pwdata[14:0];
                REG_CONTRAST:   r_contrast   <= pwdata[14:0];
                REG_BRIGHTNESS: r_brightness <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GAMMA:      prdata = {17'd0, r_gamma};
            REG_CONTRAST:   prdata = {17'd0, r_contrast};
            REG_BRIGHTNESS: prdata = {15'd0, r_brightness};
            default:        prdata = '0;
        endcase
    end

    // Effective gamma never goes below the minimum.
    logic [14:0] gamma_eff;
    assign gamma_eff = (r_gamma < 15'(GAMMA_MIN)) ? 15'(GAMMA_MIN) : r_gamma;

    // Pipeline advances while the output buffer has room.
    logic r_skid_valid;
    logic en;
    assign en      = !r_skid_valid;
    assign o_ready = en;

    // Log stage: table lookup and distance from the ramp end.
    logic [7:0]  idx_sat;
    logic [19:0] li;
    logic        r_s0_valid;
    logic        r_s0_zero;
    logic [19:0] r_s0_d;

    assign idx_sat = ({5'd0, i_ramp_index} >= ENTRIES_W) ? LAST_IDX : i_ramp_index;
    assign li      = LOG_TAB[idx_sat];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_valid;
        end
        if (en) begin
            r_s0_zero <= (idx_sat == 8'd0);
            r_s0_d    <= (li > LOG_N) ? 20'd0 : LOG_N - li;
        end
    end

    // Exponent e = d * 4096 / gamma.
    logic        div_valid;
    logic        div_zero;
    logic [31:0] div_quo;

    glut_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_valid),
        .i_tag   (r_s0_zero),
        .i_num   ({r_s0_d, 12'd0}),
        .i_den   (gamma_eff),
        .o_valid (div_valid),
        .o_tag   (div_zero),
        .o_quo   (div_quo)
    );

    // Curve value y = 2^-e.
    logic        exp_valid;
    logic [30:0] exp_y;

    glut_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_zero  (div_zero),
        .i_e     (div_quo),
        .o_valid (exp_valid),
        .o_y     (exp_y)
    );

    // Contrast product, then scale by 255 and add brightness.
    logic        r_s1_valid;
    logic [45:0] r_s1_p;
    logic        r_s2_valid;
    logic signed [20:0] r_s2_v;
    logic [53:0] scaled;
    logic signed [20:0] n_v;

    assign scaled = {r_s1_p, 8'd0} - {8'd0, r_s1_p};
    assign n_v    = $signed({1'b0, scaled[53:34]})
                  + {{4{r_brightness[16]}}, $signed(r_brightness)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= exp_valid;
            r_s2_valid <= r_s1_valid;
        end
        if (en) begin
            r_s1_p <= exp_y * r_contrast;
            r_s2_v <= n_v;
        end
    end

    // Clamp to the 8-bit level range.
    logic [7:0] level;
    logic       clamp;

    always_comb begin
        if (r_s2_v < 0) begin
            level = 8'd0;
            clamp = 1'b1;
        end else if (r_s2_v > 21'sd65280) begin
            level = 8'd255;
            clamp = 1'b1;
        end else begin
            level = r_s2_v[15:8];
            clamp = 1'b0;
        end
    end

    // Output register with one skid entry behind it.
    logic        r_out_valid;
    logic [15:0] r_out_word;
    logic        r_out_clamp;
    logic [15:0] r_skid_word;
    logic        r_skid_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r_s2_valid;
            end
        end else if (r_s2_valid && en) begin
            r_skid_valid <= 1'b1;
        end
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_word  <= r_skid_word;
                r_out_clamp <= r_skid_clamp;
            end else begin
                r_out_word  <= {level, 8'd0};
                r_out_clamp <= clamp;
            end
        end else if (en) begin
            r_skid_word  <= {level, 8'd0};
            r_skid_clamp <= clamp;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_ramp_word     = r_out_word;
    assign o_level_clamped = r_out_clamp;

endmodule

>>> tb/gamma_ramp_entry_generator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamma ramp entry generator testbench
// Drives ramp indices through the valid/ready input under several register
// settings written over the APB port. Each accepted request is predicted
// by a local fixed-point model of the log2, divide, exp2 and scale path.
// Every returned ramp word and clamp flag is compared in order.
// ----------------------------------------------------------------------------
module gamma_ramp_entry_generator_unit_tb;
    import glut_pkg::*;

    localparam int          PIPE_DRAIN      = 40;
    localparam int          LONG_HOLD       = 300;
    localparam logic [3:0]  UNUSED_REG_ADDR = 4'd12;
    localparam longint      ONE_Q30         = 64'd1 << 30;
    localparam int          RAMP_N          = 256;

    typedef struct packed {
        logic [15:0] word;
        logic        clamped;
    } t_ramp_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_ramp_index;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_ramp_word;
    logic        o_level_clamped;

    // Shadow copy of the configuration registers.
    logic [14:0] gamma_q12;
    logic [14:0] contrast_q12;
    logic [16:0] bright_q8;

    logic [7:0]   pending_index[$];
    t_ramp_result expected_ramp[$];
    int           errors;
    int           send_gap;
    int           hold_left;
    bit           in_took;
    bit           quiet_mode;
    bit           hold_request;

    gamma_ramp_entry_generator_unit i_dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run.
    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint unsigned root64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Log2 in Q16: top bit position plus sixteen bits from mantissa squaring.
    function automatic longint unsigned log2_fix(input longint unsigned n);
        longint unsigned top;
        longint unsigned m;
        longint unsigned frac;
        top = 0;
        frac = 0;
        while (top < 13 && (n >> (top + 1)) != 0) top++;
        m = n << (30 - top);
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (ONE_Q30 << 1)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (top << 16) | frac;
    endfunction

    // 2^-e with e in Q16, result in Q30.
    function automatic longint unsigned pow2_neg(input longint unsigned e);
        longint unsigned r;
        longint unsigned c;
        r = ONE_Q30;
        c = ONE_Q30 >> 1;
        for (int j = 1; j <= 16; j++) begin
            c = root64(c << 30);
            if ((e >> (16 - j)) & 1) r = (r * c) >> 30;
        end
        if ((e >> 16) >= 31) return 0;
        return r >> (e >> 16);
    endfunction

    // Ramp word and clamp flag for one index under the shadow settings.
    function automatic t_ramp_result ramp_entry(input logic [7:0] idx);
        t_ramp_result res;
        longint unsigned g;
        longint unsigned ln;
        longint unsigned li;
        longint unsigned d;
        longint unsigned curve;
        longint lvl;
        g = (gamma_q12 < GAMMA_MIN) ? GAMMA_MIN : gamma_q12;
        curve = 0;
        if (idx != 0) begin
            ln = log2_fix(RAMP_N);
            li = log2_fix(idx);
            d = (li > ln) ? 0 : ln - li;
            curve = (255 * pow2_neg((d * 4096) / g) * contrast_q12) >> 34;
        end
        lvl = longint'(curve) + longint'({{47{bright_q8[16]}}, bright_q8});
        res.clamped = 1'b1;
        if (lvl < 0) begin
            res.word = 16'd0;
        end else if (lvl > MAX_LEVEL_Q8) begin
            res.word = 16'hFF00;
        end else begin
            res.word = {lvl[15:8], 8'd0};
            res.clamped = 1'b0;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Request driver: holds each request until accepted, then maybe idles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !in_took)) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_index.size() > 0) begin
                i_ramp_index <= pending_index.pop_front();
                i_valid <= 1'b1;
                send_gap = quiet_mode ? 0 : pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold when requested.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else if (quiet_mode) begin
            i_ready <= 1'b1;
        end else begin
            hold_left = pick_gap();
            i_ready <= (hold_left == 0);
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance.
    always @(posedge i_clk) begin
        t_ramp_result exp_r;
        in_took = i_valid && o_ready && i_rst_n;
        if (in_took) expected_ramp.push_back(ramp_entry(i_ramp_index));
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_ramp.size() == 0) begin
                $display("%0t: unexpected result word=%h clamped=%b", $realtime,
                         o_ramp_word, o_level_clamped);
                errors++;
            end else begin
                exp_r = expected_ramp.pop_front();
                if (o_ramp_word !== exp_r.word) begin
                    $display("%0t: ramp_word expected %h actual %h", $realtime,
                             exp_r.word, o_ramp_word);
                    errors++;
                end
                if (o_level_clamped !== exp_r.clamped) begin
                    $display("%0t: level_clamped expected %b actual %b", $realtime,
                             exp_r.clamped, o_level_clamped);
                    errors++;
                end
            end
        end
    end

    // One APB write; the shadow follows the register map.
    task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            {REG_GAMMA, 2'b00}:      gamma_q12 = data[14:0];
            {REG_CONTRAST, 2'b00}:   contrast_q12 = data[14:0];
            {REG_BRIGHTNESS, 2'b00}: bright_q8 = data[16:0];
            default: ;
        endcase
    endtask

    task automatic set_curve(input logic [14:0] g, input logic [14:0] c,
                             input logic [16:0] b);
        reg_write({REG_GAMMA, 2'b00}, {17'd0, g});
        reg_write({REG_CONTRAST, 2'b00}, {17'd0, c});
        reg_write({REG_BRIGHTNESS, 2'b00}, {15'd0, b});
    endtask

    // Wait until every request has been answered and the pipe has drained.
    task automatic drain();
        while (pending_index.size() > 0 || i_valid || expected_ramp.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic sweep_corners();
        logic [7:0] corners [7];
        corners = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd254, 8'd255};
        foreach (corners[k])
            pending_index.push_back(corners[k]);
    endtask

    task automatic random_indices(input int n);
        for (int k = 0; k < n; k++) pending_index.push_back(8'($urandom_range(0, 255)));
    endtask

    // Stimulus.
    initial begin
        logic [14:0] g;
        errors = 0;
        send_gap = 0;
        hold_left = 0;
        in_took = 1'b0;
        quiet_mode = 1'b0;
        hold_request = 1'b0;
        gamma_q12 = 15'd4096;
        contrast_q12 = 15'd4096;
        bright_q8 = 17'd256;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_ramp_index = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, index extremes and alternating bit patterns.
        sweep_corners();
        pending_index.push_back(8'h55);
        pending_index.push_back(8'hAA);
        drain();

        // Gamma below the floor, zero gain, most negative offset.
        set_curve(15'd0, 15'd0, 17'h10000);
        sweep_corners();
        drain();
        set_curve(15'd40, 15'd32767, 17'h0FFFF);
        sweep_corners();
        drain();
        // Write to an unused address must be ignored.
        reg_write(UNUSED_REG_ADDR, 32'hFFFF_FFFF);
        set_curve(15'd32767, 15'd32767, 17'h1FFFF);
        sweep_corners();
        drain();

        // Random settings; a few phases run with no idling and one with a long hold.
        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 3))
                0:       g = 15'($urandom_range(0, 41));
                1:       g = 15'($urandom_range(16384, 32767));
                default: g = 15'($urandom_range(41, 16384));
            endcase
            set_curve(g, 15'($urandom_range(0, 32767)), 17'($urandom));
            quiet_mode = (p == 2 || p == 7);
            if (p == 4) hold_request = 1'b1;
            random_indices(160);
            drain();
        end
        quiet_mode = 1'b0;

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> gamma_ramp_entry_generator_unit.f
hw/rtl/glut_pkg.sv
hw/rtl/glut_div.sv
hw/rtl/glut_exp.sv
hw/rtl/gamma_ramp_entry_generator_unit.sv
tb/gamma_ramp_entry_generator_unit_tb.sv
